// ----- src/yuv2rgb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package yuv2rgb_pkg;

  localparam int unsigned CompW    = 8;
  localparam int unsigned InWords  = 6;
  localparam int unsigned OutWords = 12;
  localparam int unsigned PixCnt   = 4;
  localparam int unsigned InDataW  = InWords * CompW;
  localparam int unsigned OutDataW = OutWords * CompW;
  localparam int unsigned CfgIdxW  = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCbGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCrGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGCbGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGCrGain  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLumaGain = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLumaFlr  = 3'd5;

  // full-range JPEG coefficient set
  localparam logic [CompW-1:0] RstCbGain   = 8'd113;
  localparam logic [CompW-1:0] RstCrGain   = 8'd90;
  localparam logic [CompW-1:0] RstGCbGain  = 8'd44;
  localparam logic [CompW-1:0] RstGCrGain  = 8'd91;
  localparam logic [CompW-1:0] RstLumaGain = 8'd128;
  localparam logic [CompW-1:0] RstLumaFlr  = 8'd0;

  function automatic logic [CompW-1:0] clamp8(input logic signed [11:0] x);
    logic [CompW-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > 12'sd255) begin
      r = '1;
    end else begin
      r = x[CompW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/yuv420_to_rgb_fixed.sv -----
// 4:2:0 YCbCr to RGB converter, one 2x2 pixel block per word.
//
// Input stream (s_axis_*): one word carries four luma samples and the shared
// Cb/Cr pair of a 2x2 block. Output stream (m_axis_*): one word carries the
// twelve clamped RGB bytes of that block. Every input word yields exactly one
// output word, in order.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 cb_gain,
// 1 cr_gain, 2 green_cb_gain, 3 green_cr_gain, 4 luma_gain, 5 luma_floor);
// other indexes are ignored. Write only while the pipe is empty.
// A word accepted on the input enters the input register; its result is
// loaded into the output register once that register is free, and then
// m_axis_tvalid rises. Throughput is one block per cycle while the receiver
// does not stall; the rate is set by the single pass through four 9x8 chroma
// and four 9x10 luma multipliers and the clamp between the two registers.
// Reset clears both valid flags and loads the full-range JPEG coefficients.
// When the receiver stalls, the output word holds and an empty input
// register still takes one more word; after that s_axis_tready drops until
// the output drains.
`timescale 1ns / 1ps
`default_nettype none

module yuv420_to_rgb_fixed
  import yuv2rgb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CompW-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // red/green/blue top_left, red/green/blue top_right,
  // red/green/blue bottom_left, red/green/blue bottom_right
  output logic [OutDataW-1:0]       m_axis_tdata
);

  logic [CompW-1:0] cb_gain_q, cr_gain_q, gcb_gain_q, gcr_gain_q;
  logic [CompW-1:0] luma_gain_q, luma_flr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_gain_q   <= RstCbGain;
      cr_gain_q   <= RstCrGain;
      gcb_gain_q  <= RstGCbGain;
      gcr_gain_q  <= RstGCrGain;
      luma_gain_q <= RstLumaGain;
      luma_flr_q  <= RstLumaFlr;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCbGain:   cb_gain_q   <= cfg_data_i;
        RegCrGain:   cr_gain_q   <= cfg_data_i;
        RegGCbGain:  gcb_gain_q  <= cfg_data_i;
        RegGCrGain:  gcr_gain_q  <= cfg_data_i;
        RegLumaGain: luma_gain_q <= cfg_data_i;
        RegLumaFlr:  luma_flr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, in_accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (out_free) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_free ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  logic [InDataW-1:0]  in_data_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= s_axis_tdata;
    end
    if (out_free && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tdata = out_data_q;

  // chroma offsets; c - 128 is the byte with its top bit flipped
  logic signed [CompW-1:0]  u_s, v_s;
  logic signed [CompW:0]    cb_gain_s, cr_gain_s, gcb_gain_s, gcr_gain_s, luma_gain_s;
  logic signed [16:0]       red_prod, blue_prod, gcb_prod, gcr_prod;
  logic signed [17:0]       green_sum;
  logic signed [10:0]       red_off, blue_off, green_off;

  assign u_s = {~in_data_q[4*CompW+7], in_data_q[4*CompW +: 7]};
  assign v_s = {~in_data_q[5*CompW+7], in_data_q[5*CompW +: 7]};

  assign cb_gain_s   = {1'b0, cb_gain_q};
  assign cr_gain_s   = {1'b0, cr_gain_q};
  assign gcb_gain_s  = {1'b0, gcb_gain_q};
  assign gcr_gain_s  = {1'b0, gcr_gain_q};
  assign luma_gain_s = {1'b0, luma_gain_q};

  assign red_prod  = cr_gain_s * v_s;
  assign blue_prod = cb_gain_s * u_s;
  assign gcb_prod  = gcb_gain_s * u_s;
  assign gcr_prod  = gcr_gain_s * v_s;
  assign green_sum = gcb_prod + gcr_prod;

  // arithmetic shifts: keep the upper bits, floor rounding
  assign red_off   = red_prod[16:6];
  assign blue_off  = blue_prod[16:6];
  assign green_off = green_sum[17:7];

  always_comb begin
    logic signed [9:0]  y_diff;
    logic signed [17:0] luma_prod;
    logic signed [10:0] luma;
    logic signed [11:0] r_sum, g_sum, b_sum;
    out_data_d = '0;
    for (int p = 0; p < PixCnt; p++) begin
      y_diff    = $signed({2'b00, in_data_q[p*CompW +: CompW]}) -
                  $signed({2'b00, luma_flr_q});
      luma_prod = luma_gain_s * y_diff;
      luma      = luma_prod[17:7];
      r_sum     = {luma[10], luma} + {red_off[10], red_off};
      g_sum     = {luma[10], luma} - {green_off[10], green_off};
      b_sum     = {luma[10], luma} + {blue_off[10], blue_off};
      out_data_d[(3*p+0)*CompW +: CompW] = clamp8(r_sum);
      out_data_d[(3*p+1)*CompW +: CompW] = clamp8(g_sum);
      out_data_d[(3*p+2)*CompW +: CompW] = clamp8(b_sum);
    end
  end

endmodule

`default_nettype wire

// ----- src/yuv2rgb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module yuv2rgb_checker
  import yuv2rgb_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  // a stalled output word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // and keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  // an empty output stage never backpressures the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a word appearing at the output was taken in and passed through the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output word without matching input");

endmodule

bind yuv420_to_rgb_fixed yuv2rgb_checker u_yuv2rgb_checker (.*);

`default_nettype wire
